// File: hw/rtl/sdpv_pkg.sv
package sdpv_pkg;

	localparam int MOD_W = 32;
	localparam logic [31:0] MOD_MASK = 32'((64'd1 << MOD_W) - 64'd1);

	localparam logic [63:0] SM_GOLDEN  = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] SM_MUL1    = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] SM_MUL2    = 64'h94d049bb133111eb;
	localparam logic [63:0] PRNG_RESET = 64'h000deadbeef69420;
	localparam int SH1 = 30;
	localparam int SH2 = 27;
	localparam int SH3 = 31;

	localparam logic [31:0] MODULUS_RESET = 32'd7;

	// configuration register indexes
	localparam logic CFG_MODULUS  = 1'b0;
	localparam logic CFG_HASH_KEY = 1'b1;

	localparam int PC_W = 6;
	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [3:0] {
		R_ACC, R_SQ, R_EX, R_A, R_T, R_C, R_R, R_X, R_G, R_Y, R_TI, R_RI, R_GX
	} rsel_t;

	typedef enum logic [1:0] {N_REG, N_H, N_PROD, N_DIFF} nsel_t;

	typedef enum logic [1:0] {HS_PRNG, HS_PROVE, HS_VERIFY} hsel_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_RED, OP_MUL, OP_HASH, OP_SET1, OP_MOV, OP_SHR, OP_PRNG,
		OP_SKIP0, OP_LOOP, OP_END
	} op_t;

	typedef struct packed {
		op_t   op;
		rsel_t dst;
		rsel_t sa;
		rsel_t sb;
		nsel_t ns;
		logic  div_q;
		hsel_t hs;
		pc_t   tgt;
	} uinst_t;

	typedef struct packed {
		logic   load;
		logic   issue;
		uinst_t ui;
		logic   out_ld;
		logic   zero;
		logic   func;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic ex0;
		logic p_small;
	} dp_sts_t;

	localparam int PC_PROVE  = 0;
	localparam int PC_VERIFY = 34;

	function automatic uinst_t mk(op_t op, rsel_t dst, rsel_t sa, rsel_t sb, nsel_t ns,
		logic dq, hsel_t hs, int tgt);
		uinst_t u;
		u.op    = op;
		u.dst   = dst;
		u.sa    = sa;
		u.sb    = sb;
		u.ns    = ns;
		u.div_q = dq;
		u.hs    = hs;
		u.tgt   = PC_W'(tgt);
		return u;
	endfunction

	function automatic uinst_t u_op(op_t op);
		return mk(op, R_ACC, R_ACC, R_ACC, N_REG, 1'b0, HS_PRNG, 0);
	endfunction

	function automatic uinst_t u_red(nsel_t ns, rsel_t sa, logic dq, rsel_t dst);
		return mk(OP_RED, dst, sa, R_ACC, ns, dq, HS_PRNG, 0);
	endfunction

	function automatic uinst_t u_mul(rsel_t sa, rsel_t sb);
		return mk(OP_MUL, R_ACC, sa, sb, N_REG, 1'b0, HS_PRNG, 0);
	endfunction

	function automatic uinst_t u_mov(rsel_t dst, rsel_t sa);
		return mk(OP_MOV, dst, sa, R_ACC, N_REG, 1'b0, HS_PRNG, 0);
	endfunction

	function automatic uinst_t u_hash(hsel_t hs);
		return mk(OP_HASH, R_ACC, R_ACC, R_ACC, N_REG, 1'b0, hs, 0);
	endfunction

	// one step of b^(e mod (p-1)) mod p, square-and-multiply from the low bit
	function automatic uinst_t pow_step(int k, rsel_t b, rsel_t e, int start);
		uinst_t u;
		case (k)
			0:       u = u_red(N_REG, b, 1'b0, R_SQ);
			1:       u = u_red(N_REG, e, 1'b1, R_EX);
			2:       u = u_op(OP_SET1);
			3:       u = u_op(OP_SKIP0);
			4:       u = u_mul(R_ACC, R_SQ);
			5:       u = u_red(N_PROD, R_ACC, 1'b0, R_ACC);
			6:       u = u_mul(R_SQ, R_SQ);
			7:       u = u_red(N_PROD, R_ACC, 1'b0, R_SQ);
			8:       u = u_op(OP_SHR);
			9:       u = mk(OP_LOOP, R_ACC, R_ACC, R_ACC, N_REG, 1'b0, HS_PRNG, start + 3);
			default: u = u_op(OP_NOP);
		endcase
		return u;
	endfunction

	function automatic uinst_t urom(pc_t pc);
		int     k;
		uinst_t u;
		k = int'(pc);
		u = u_op(OP_END);
		if (k == 0)
			u = u_hash(HS_PRNG);
		else if (k == 1)
			u = u_op(OP_PRNG);
		else if (k == 2)
			u = u_red(N_H, R_ACC, 1'b0, R_A);
		else if (k >= 3 && k <= 12)
			u = pow_step(k - 3, R_G, R_A, 3);
		else if (k == 13)
			u = u_mov(R_T, R_ACC);
		else if (k >= 14 && k <= 23)
			u = pow_step(k - 14, R_G, R_X, 14);
		else if (k == 24)
			u = u_mov(R_GX, R_ACC);
		else if (k == 25)
			u = u_hash(HS_PROVE);
		else if (k == 26)
			u = u_red(N_H, R_ACC, 1'b0, R_C);
		else if (k == 27)
			u = u_red(N_REG, R_C, 1'b1, R_SQ);
		else if (k == 28)
			u = u_red(N_REG, R_X, 1'b1, R_EX);
		else if (k == 29)
			u = u_mul(R_SQ, R_EX);
		else if (k == 30)
			u = u_red(N_PROD, R_ACC, 1'b1, R_ACC);
		else if (k == 31)
			u = u_red(N_REG, R_A, 1'b1, R_SQ);
		else if (k == 32)
			u = u_red(N_DIFF, R_ACC, 1'b1, R_R);
		else if (k == 33)
			u = u_op(OP_END);
		else if (k == 34)
			u = u_hash(HS_VERIFY);
		else if (k == 35)
			u = u_red(N_H, R_ACC, 1'b0, R_C);
		else if (k >= 36 && k <= 45)
			u = pow_step(k - 36, R_Y, R_C, 36);
		else if (k == 46)
			u = u_mov(R_A, R_ACC);
		else if (k >= 47 && k <= 56)
			u = pow_step(k - 47, R_G, R_RI, 47);
		else if (k == 57)
			u = u_mul(R_A, R_ACC);
		else if (k == 58)
			u = u_red(N_PROD, R_ACC, 1'b0, R_ACC);
		return u;
	endfunction

endpackage

// File: hw/rtl/schnorr_dlog_prove_verify_core.sv
// Two 32-step modular exponentiations dominate the time of a prove or a verify.
// The set bits of each reduced exponent decide how long a word takes: every step runs
// a squaring multiply-reduce pass, and a step whose bit is set runs one more; each pass
// waits on the bit-serial remainder unit. A modulus below two skips the micro-program.
// Throughput: one word at a time; the next word is taken once the result is in the
// output register, which holds it while out_stall is high.
// Reset: arst_n clears control, sets modulus to 7, hash_key to 0, PRNG to its seed.
module schnorr_dlog_prove_verify_core import sdpv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input word
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [31:0] secret_exp,
	input  logic [31:0] base,
	input  logic [31:0] public_key,
	input  logic [31:0] commit_in,
	input  logic [31:0] response_in,
	// result word
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] commit_out,
	output logic [31:0] response_out,
	output logic [31:0] challenge,
	output logic        valid_res,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Take configuration at any time; software must write it only while idle (not enforced here).
	assign cfg_ready = 1'b1;

	// Sequencer: walks the micro-program, handles the square-and-multiply loop
	// and the output handshake.
	sdpv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: operand registers, 32x32 multiplier, remainder unit, keyed hash,
	// PRNG and the output register.
	sdpv_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.secret_exp   (secret_exp),
		.base         (base),
		.public_key   (public_key),
		.commit_in    (commit_in),
		.response_in  (response_in),
		.commit_out   (commit_out),
		.response_out (response_out),
		.challenge    (challenge),
		.valid_res    (valid_res)
	);

endmodule

// File: hw/rtl/sdpv_ctrl.sv
module sdpv_ctrl import sdpv_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic    func,
	output logic    out_valid,
	input  logic    out_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_DONE} state_t;

	state_t     state_q;
	pc_t        pc_q;
	logic [4:0] cnt_q;
	logic       func_q;
	logic       zero_q;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;
	uinst_t     ui;

	assign ui        = urom(pc_q);
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = accept;
		cmd.issue  = (state_q == S_ISSUE);
		cmd.ui     = ui;
		cmd.out_ld = (state_q == S_DONE) && out_free;
		cmd.zero   = zero_q;
		cmd.func   = func_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			cnt_q       <= '0;
			func_q      <= 1'b0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q <= func;
						zero_q <= sts.p_small;
						pc_q   <= func ? PC_W'(PC_VERIFY) : PC_W'(PC_PROVE);
						state_q <= sts.p_small ? S_DONE : S_ISSUE;
					end
				end
				S_ISSUE: begin
					case (ui.op)
						OP_SKIP0: begin
							pc_q <= sts.ex0 ? pc_q + 1'b1 : pc_q + PC_W'(3);
						end
						OP_LOOP: begin
							if (cnt_q != '1) begin
								cnt_q <= cnt_q + 1'b1;
								pc_q  <= ui.tgt;
							end else begin
								pc_q <= pc_q + 1'b1;
							end
						end
						OP_END: begin
							state_q <= S_DONE;
						end
						OP_SET1: begin
							cnt_q   <= '0;
							pc_q    <= pc_q + 1'b1;
							state_q <= S_WAIT;
						end
						default: begin
							pc_q    <= pc_q + 1'b1;
							state_q <= S_WAIT;
						end
					endcase
				end
				S_WAIT: begin
					if (!sts.busy)
						state_q <= S_ISSUE;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/sdpv_dp.sv
module sdpv_dp import sdpv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic [31:0] secret_exp,
	input  logic [31:0] base,
	input  logic [31:0] public_key,
	input  logic [31:0] commit_in,
	input  logic [31:0] response_in,
	output logic [31:0] commit_out,
	output logic [31:0] response_out,
	output logic [31:0] challenge,
	output logic        valid_res
);

	typedef enum logic [3:0] {
		H_IDLE, H_ADDG, H_X1, H_P0, H_P1, H_P2, H_P3, H_X2, H_Q0, H_Q1, H_Q2, H_Q3, H_X3
	} hstep_t;

	logic [31:0] modulus_q;
	logic [63:0] key_q;
	logic [63:0] prng_q;
	logic [31:0] p_eff;
	logic [31:0] q_eff;

	logic [31:0] acc_q, sq_q, ex_q, a_q, t_q, c_q, r_q, x_q, g_q, y_q, ti_q, ri_q, gx_q;
	logic [63:0] prod_q;

	logic        red_busy_q;
	logic [5:0]  red_cnt_q;
	logic [63:0] num_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;
	rsel_t       red_dst_q;
	logic [32:0] rem2;
	logic [31:0] rem_n;
	logic        red_fin;

	hstep_t      hstep_q;
	logic [63:0] z_q, w_q, pp_q, h_q;
	logic [63:0] hin;
	logic [63:0] mconst;
	logic [31:0] ma, mb;

	logic [31:0] rd_a, rd_b;
	logic [63:0] nsrc;
	logic [32:0] diff;
	logic        wr_en;
	rsel_t       wr_sel;
	logic [31:0] wr_val;
	logic        iss;

	logic [31:0] commit_q, response_q, challenge_q;
	logic        valid_res_q;

	function automatic logic [31:0] rd(rsel_t s, logic [31:0] acc, logic [31:0] sq,
		logic [31:0] ex, logic [31:0] a, logic [31:0] t, logic [31:0] c, logic [31:0] r,
		logic [31:0] x, logic [31:0] g, logic [31:0] y, logic [31:0] ti, logic [31:0] ri,
		logic [31:0] gx);
		logic [31:0] v;
		case (s)
			R_ACC:   v = acc;
			R_SQ:    v = sq;
			R_EX:    v = ex;
			R_A:     v = a;
			R_T:     v = t;
			R_C:     v = c;
			R_R:     v = r;
			R_X:     v = x;
			R_G:     v = g;
			R_Y:     v = y;
			R_TI:    v = ti;
			R_RI:    v = ri;
			R_GX:    v = gx;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign p_eff = modulus_q & MOD_MASK;
	assign q_eff = p_eff - 32'd1;
	assign iss   = cmd.issue;

	assign rd_a = rd(cmd.ui.sa, acc_q, sq_q, ex_q, a_q, t_q, c_q, r_q, x_q, g_q, y_q,
		ti_q, ri_q, gx_q);
	assign rd_b = rd(cmd.ui.sb, acc_q, sq_q, ex_q, a_q, t_q, c_q, r_q, x_q, g_q, y_q,
		ti_q, ri_q, gx_q);

	// sq + q - acc with both below q: stays under 2q
	assign diff = {1'b0, sq_q} + {1'b0, q_eff} - {1'b0, acc_q};

	always_comb begin
		case (cmd.ui.ns)
			N_REG:   nsrc = {32'd0, rd_a};
			N_H:     nsrc = h_q;
			N_PROD:  nsrc = prod_q;
			N_DIFF:  nsrc = {31'd0, diff};
			default: nsrc = '0;
		endcase
	end

	// restoring remainder, one numerator bit a cycle
	assign rem2    = {rem_q, num_q[63]};
	assign rem_n   = (rem2 >= {1'b0, div_q}) ? 32'(rem2 - {1'b0, div_q}) : rem2[31:0];
	assign red_fin = red_busy_q && (red_cnt_q == '1);

	always_comb begin
		wr_en  = 1'b0;
		wr_sel = R_ACC;
		wr_val = '0;
		if (red_fin) begin
			wr_en  = 1'b1;
			wr_sel = red_dst_q;
			wr_val = rem_n;
		end else if (iss && cmd.ui.op == OP_MOV) begin
			wr_en  = 1'b1;
			wr_sel = cmd.ui.dst;
			wr_val = rd_a;
		end else if (iss && cmd.ui.op == OP_SET1) begin
			wr_en  = 1'b1;
			wr_sel = R_ACC;
			wr_val = 32'd1;
		end else if (iss && cmd.ui.op == OP_SHR) begin
			wr_en  = 1'b1;
			wr_sel = R_EX;
			wr_val = ex_q >> 1;
		end
	end

	always_comb begin
		case (cmd.ui.hs)
			HS_PRNG:   hin = prng_q;
			HS_PROVE:  hin = {32'd0, g_q} + {32'd0, gx_q} + {32'd0, t_q};
			HS_VERIFY: hin = {32'd0, g_q} + {32'd0, y_q} + {32'd0, ti_q};
			default:   hin = '0;
		endcase
	end

	always_comb begin
		case (hstep_q)
			H_Q0, H_Q1, H_Q2, H_Q3: mconst = SM_MUL2;
			default:                mconst = SM_MUL1;
		endcase
		case (hstep_q)
			H_P1, H_Q1: begin
				ma = z_q[31:0];
				mb = mconst[63:32];
			end
			H_P2, H_Q2: begin
				ma = z_q[63:32];
				mb = mconst[31:0];
			end
			default: begin
				ma = z_q[31:0];
				mb = mconst[31:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MODULUS_RESET;
			key_q      <= '0;
			prng_q     <= PRNG_RESET;
			red_busy_q <= 1'b0;
			red_cnt_q  <= '0;
			hstep_q    <= H_IDLE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODULUS:  modulus_q <= cfg_data[31:0];
					CFG_HASH_KEY: key_q     <= cfg_data;
					default:      ;
				endcase
			end
			if (iss && cmd.ui.op == OP_PRNG)
				prng_q <= h_q;

			if (iss && cmd.ui.op == OP_RED) begin
				red_busy_q <= 1'b1;
				red_cnt_q  <= '0;
			end else if (red_busy_q) begin
				red_cnt_q <= red_cnt_q + 1'b1;
				if (red_fin)
					red_busy_q <= 1'b0;
			end

			case (hstep_q)
				H_IDLE:  if (iss && cmd.ui.op == OP_HASH) hstep_q <= H_ADDG;
				H_ADDG:  hstep_q <= H_X1;
				H_X1:    hstep_q <= H_P0;
				H_P0:    hstep_q <= H_P1;
				H_P1:    hstep_q <= H_P2;
				H_P2:    hstep_q <= H_P3;
				H_P3:    hstep_q <= H_X2;
				H_X2:    hstep_q <= H_Q0;
				H_Q0:    hstep_q <= H_Q1;
				H_Q1:    hstep_q <= H_Q2;
				H_Q2:    hstep_q <= H_Q3;
				H_Q3:    hstep_q <= H_X3;
				H_X3:    hstep_q <= H_IDLE;
				default: hstep_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q  <= secret_exp;
			g_q  <= base;
			y_q  <= public_key;
			ti_q <= commit_in;
			ri_q <= response_in;
		end
		if (wr_en) begin
			case (wr_sel)
				R_ACC:   acc_q <= wr_val;
				R_SQ:    sq_q  <= wr_val;
				R_EX:    ex_q  <= wr_val;
				R_A:     a_q   <= wr_val;
				R_T:     t_q   <= wr_val;
				R_C:     c_q   <= wr_val;
				R_R:     r_q   <= wr_val;
				R_GX:    gx_q  <= wr_val;
				default: ;
			endcase
		end
		if (iss && cmd.ui.op == OP_MUL)
			prod_q <= rd_a * rd_b;

		if (iss && cmd.ui.op == OP_RED) begin
			num_q     <= nsrc;
			rem_q     <= '0;
			div_q     <= cmd.ui.div_q ? q_eff : p_eff;
			red_dst_q <= cmd.ui.dst;
		end else if (red_busy_q) begin
			num_q <= num_q << 1;
			rem_q <= rem_n;
		end

		// one 32x32 partial product a cycle, summed in the cycle after
		pp_q <= ma * mb;
		case (hstep_q)
			H_IDLE:     if (iss && cmd.ui.op == OP_HASH) z_q <= hin + key_q;
			H_ADDG:     z_q <= z_q + SM_GOLDEN;
			H_X1:       z_q <= z_q ^ (z_q >> SH1);
			H_P1, H_Q1: w_q <= pp_q;
			H_P2, H_Q2: w_q <= w_q + {pp_q[31:0], 32'd0};
			H_P3, H_Q3: z_q <= w_q + {pp_q[31:0], 32'd0};
			H_X2:       z_q <= z_q ^ (z_q >> SH2);
			H_X3:       h_q <= z_q ^ (z_q >> SH3);
			default:    ;
		endcase

		if (cmd.out_ld) begin
			commit_q    <= (cmd.zero || cmd.func) ? 32'd0 : t_q;
			response_q  <= (cmd.zero || cmd.func) ? 32'd0 : r_q;
			challenge_q <= cmd.zero ? 32'd0 : c_q;
			valid_res_q <= !cmd.zero && cmd.func && (ti_q == acc_q);
		end
	end

	assign sts.busy    = red_busy_q || (hstep_q != H_IDLE);
	assign sts.ex0     = ex_q[0];
	assign sts.p_small = (p_eff < 32'd2);

	assign commit_out   = commit_q;
	assign response_out = response_q;
	assign challenge    = challenge_q;
	assign valid_res    = valid_res_q;

endmodule
